// File: rtl/turn_then_drive_waypoint_follower_top_defines.svh
// assertion macros used by the top-level rtl
`ifndef TURN_THEN_DRIVE_WAYPOINT_FOLLOWER_TOP_DEFINES_SVH
`define TURN_THEN_DRIVE_WAYPOINT_FOLLOWER_TOP_DEFINES_SVH

// same-cycle implication
`define TTDW_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TTDW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/ttdw_pkg.sv
package ttdw_pkg;

	localparam int WAYPOINT_DEPTH_DEF = 64;
	localparam int CORDIC_STEPS_DEF = 16;

	localparam logic [1:0] OP_POSE = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_COMMIT = 2'd2;

	localparam logic [1:0] REG_LIN_LIMIT = 2'd0;
	localparam logic [1:0] REG_TURN_LIMIT = 2'd1;
	localparam logic [1:0] REG_POS_TOL = 2'd2;
	localparam logic [1:0] REG_HEAD_TOL = 2'd3;

	localparam logic [30:0] LIN_LIMIT_RST = 31'd14418;
	localparam logic [14:0] TURN_LIMIT_RST = 15'd10240;
	localparam logic [30:0] POS_TOL_RST = 31'd655;
	localparam logic [14:0] HEAD_TOL_RST = 15'd41;

	localparam logic signed [35:0] PI_Q28 = 36'sd843314857;
	localparam logic signed [35:0] TWO_PI_Q28 = 36'sd1686629714;

	localparam logic [27:0] ATAN_TAB [10] = '{
		28'd210828714, 28'd124459457, 28'd65760959, 28'd33381290, 28'd16755422,
		28'd8385879, 28'd4193963, 28'd2097109, 28'd1048571, 28'd524287
	};

	function automatic logic [27:0] step_angle(input logic [5:0] i);
		logic [27:0] r;
		if (i < 6'd10) begin
			r = ATAN_TAB[i[3:0]];
		end else if (i <= 6'd28) begin
			r = 28'd1 << (6'd28 - i);
		end else begin
			r = 28'd0;
		end
		return r;
	endfunction

endpackage

// File: rtl/ttdw_if.sv
interface ttdw_in_if;
	logic valid;
	logic ready;
	logic [1:0] op;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [14:0] heading;
	logic [5:0] slot;
	logic [6:0] waypoint_total;

	modport source(output valid, op, pos_x, pos_y, heading, slot, waypoint_total,
		input ready);
	modport sink(input valid, op, pos_x, pos_y, heading, slot, waypoint_total,
		output ready);
endinterface

interface ttdw_out_if;
	logic valid;
	logic ready;
	logic [30:0] linear_velocity;
	logic signed [15:0] angular_velocity;
	logic finished;
	logic [6:0] target_index;

	modport source(output valid, linear_velocity, angular_velocity, finished,
		target_index, input ready);
	modport sink(input valid, linear_velocity, angular_velocity, finished,
		target_index, output ready);
endinterface

// File: rtl/ttdw_ram.sv
module ttdw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: rtl/ttdw_cordic.sv
module ttdw_cordic #(
	parameter int STEPS = ttdw_pkg::CORDIC_STEPS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [32:0] dx,
	input logic signed [32:0] dy,
	output logic done,
	output logic signed [32:0] angle
);
	localparam int IW = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam logic [1:0] C_IDLE = 2'd0;
	localparam logic [1:0] C_NORM = 2'd1;
	localparam logic [1:0] C_ROT = 2'd2;
	localparam logic signed [43:0] LIM40 = 44'sh100_0000_0000;
	localparam logic signed [43:0] LIM36 = 44'sh010_0000_0000;

	logic [1:0] state_q;
	logic signed [43:0] x_q, y_q;
	logic signed [32:0] z_q;
	logic [IW-1:0] i_q;
	logic signed [43:0] x_in, y_in, xs, ys;
	logic below36, below40;
	logic signed [32:0] sa;

	assign x_in = {{11{dx[32]}}, dx};
	assign y_in = {{11{dy[32]}}, dy};
	assign below36 = (x_q < LIM36) && (x_q > -LIM36) && (y_q < LIM36) && (y_q > -LIM36);
	assign below40 = (x_q < LIM40) && (x_q > -LIM40) && (y_q < LIM40) && (y_q > -LIM40);
	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign sa = $signed({5'd0, ttdw_pkg::step_angle(6'(i_q))});
	assign done = (state_q == C_IDLE);
	assign angle = z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
		end else begin
			case (state_q)
				C_IDLE: begin
					if (start && !(dx == 33'sd0 && dy == 33'sd0)) begin
						state_q <= C_NORM;
					end
				end
				C_NORM: begin
					if (!below40) begin
						state_q <= C_ROT;
					end
				end
				C_ROT: begin
					if (i_q == IW'(STEPS - 1)) begin
						state_q <= C_IDLE;
					end
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			C_IDLE: begin
				if (start) begin
					i_q <= '0;
					if (dx[32]) begin
						z_q <= dy[32] ? -33'(ttdw_pkg::PI_Q28) : 33'(ttdw_pkg::PI_Q28);
						x_q <= -x_in;
						y_q <= -y_in;
					end else begin
						z_q <= '0;
						x_q <= x_in;
						y_q <= y_in;
					end
				end
			end
			C_NORM: begin
				if (below36) begin
					x_q <= x_q <<< 4;
					y_q <= y_q <<< 4;
				end else if (below40) begin
					x_q <= x_q <<< 1;
					y_q <= y_q <<< 1;
				end
				i_q <= '0;
			end
			C_ROT: begin
				if (!y_q[43]) begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + sa;
				end else begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - sa;
				end
				i_q <= i_q + IW'(1);
			end
			default: begin
			end
		endcase
	end
endmodule

// File: rtl/ttdw_dist.sv
module ttdw_dist (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [32:0] dx,
	input logic signed [32:0] dy,
	output logic done,
	output logic [32:0] len
);
	localparam logic [2:0] D_IDLE = 3'd0;
	localparam logic [2:0] D_SQA = 3'd1;
	localparam logic [2:0] D_SQB = 3'd2;
	localparam logic [2:0] D_SUM = 3'd3;
	localparam logic [2:0] D_ROOT = 3'd4;

	logic [2:0] state_q;
	logic [31:0] a_q, b_q;
	logic half_q;
	logic [63:0] sqa_q, sqb_q, v_q, r_q, bit_q;
	logic [32:0] ax, ay;
	logic big;
	logic [63:0] trial;

	assign ax = dx[32] ? 33'(-dx) : 33'(dx);
	assign ay = dy[32] ? 33'(-dy) : 33'(dy);
	assign big = ax[32] | ax[31] | ay[32] | ay[31];
	assign trial = r_q + bit_q;
	assign done = (state_q == D_IDLE);
	assign len = half_q ? {r_q[31:0], 1'b0} : {1'b0, r_q[31:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
		end else begin
			case (state_q)
				D_IDLE: if (start) state_q <= D_SQA;
				D_SQA: state_q <= D_SQB;
				D_SQB: state_q <= D_SUM;
				D_SUM: state_q <= D_ROOT;
				D_ROOT: if (bit_q[0]) state_q <= D_IDLE;
				default: state_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			D_IDLE: begin
				if (start) begin
					half_q <= big;
					a_q <= big ? ax[32:1] : ax[31:0];
					b_q <= big ? ay[32:1] : ay[31:0];
				end
			end
			D_SQA: sqa_q <= a_q * a_q;
			D_SQB: sqb_q <= b_q * b_q;
			D_SUM: begin
				v_q <= sqa_q + sqb_q;
				r_q <= '0;
				bit_q <= 64'd1 << 62;
			end
			D_ROOT: begin
				if (v_q >= trial) begin
					v_q <= v_q - trial;
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			default: begin
			end
		endcase
	end
endmodule

// File: rtl/turn_then_drive_waypoint_follower_top.sv
// Waypoint follower that turns in place, then drives, toward stored waypoints.
// Input channel in_ch carries one transaction per command: op 1 writes a
// waypoint slot, op 2 commits the waypoint count and restarts progress, op 0
// is a pose sample that yields one transaction on out_ch (speed, turn rate,
// finished flag and target index). Other ops are dropped.
// Configuration: cfg_we with cfg_index and cfg_data writes one limit register;
// write only while no pose sample is in flight.
// Table writes and commits complete in the idle state. A pose sample reads the
// waypoint memory, then runs the distance unit (squares plus a 32-step
// bit-serial root) alongside the atan2 unit (normalizing shifts plus
// CORDIC_STEPS rotations), then the error and limit states (S_ERR, S_FIN).
// A sample after the last waypoint goes straight to the result state.
// Results sit in an output register; in_ch is ready again as soon as the
// result is loaded. If out_ch stalls, the next result waits in the block and
// in_ch stays low until the register frees.
// Reset restores the limit registers, clears count, progress and arrived;
// the waypoint memory is not cleared.
`include "turn_then_drive_waypoint_follower_top_defines.svh"

module turn_then_drive_waypoint_follower_top #(
	parameter int WAYPOINT_DEPTH = ttdw_pkg::WAYPOINT_DEPTH_DEF,
	parameter int CORDIC_STEPS = ttdw_pkg::CORDIC_STEPS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [30:0] cfg_data,
	ttdw_in_if.sink in_ch,
	ttdw_out_if.source out_ch
);
	localparam int AW = (WAYPOINT_DEPTH > 1) ? $clog2(WAYPOINT_DEPTH) : 1;
	localparam int CW = $clog2(WAYPOINT_DEPTH + 1);
	localparam int RW = 79;
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD = 3'd1;
	localparam logic [2:0] S_CALC = 3'd2;
	localparam logic [2:0] S_ERR = 3'd3;
	localparam logic [2:0] S_FIN = 3'd4;

	logic [30:0] lin_lim_q, pos_tol_q;
	logic [14:0] turn_lim_q, head_tol_q;
	logic [2:0] state_q;
	logic [CW-1:0] count_q, pi_q;
	logic arrived_q, active_q, start_q;
	logic signed [31:0] px_q, py_q;
	logic signed [14:0] hd_q, wh_q;
	logic signed [32:0] dx_q, dy_q;
	logic signed [18:0] err_q;
	logic [32:0] dist_q;
	logic out_valid_q;

	logic ram_we;
	logic [12:0] slot_ext;
	logic [RW-1:0] rdata;
	logic c_done, d_done;
	logic signed [32:0] bearing;
	logic [32:0] dist_len;
	logic signed [35:0] e_raw, e_wrap;
	logic signed [18:0] err_new;
	logic [18:0] merr;
	logic signed [15:0] hdiff;
	logic [15:0] mhdiff;
	logic signed [18:0] a_sel;
	logic [18:0] ma;
	logic signed [15:0] ang;
	logic near, arr_next, adv;
	logic [32:0] dist0;
	logic [30:0] lin;
	logic [CW-1:0] pi_next;
	logic out_free;

	assign slot_ext = 13'(in_ch.slot);
	assign ram_we = in_ch.valid && in_ch.ready && (in_ch.op == ttdw_pkg::OP_WRITE)
		&& (slot_ext < 13'(WAYPOINT_DEPTH));
	assign in_ch.ready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || out_ch.ready;
	assign out_ch.valid = out_valid_q;

	ttdw_ram #(.WIDTH(RW), .DEPTH(WAYPOINT_DEPTH)) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(slot_ext[AW-1:0]),
		.wdata({in_ch.pos_x, in_ch.pos_y, in_ch.heading}),
		.raddr(pi_q[AW-1:0]),
		.rdata(rdata)
	);

	ttdw_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(start_q), .dx(dx_q), .dy(dy_q),
		.done(c_done), .angle(bearing)
	);

	ttdw_dist u_dist (
		.clk(clk), .arst_n(arst_n), .start(start_q), .dx(dx_q), .dy(dy_q),
		.done(d_done), .len(dist_len)
	);

	// bearing error, wrapped once and rounded to q4.12
	always_comb begin
		e_raw = 36'(bearing) - (36'(hd_q) <<< 16);
		if (e_raw > ttdw_pkg::PI_Q28) begin
			e_wrap = e_raw - ttdw_pkg::TWO_PI_Q28;
		end else if (e_raw < -ttdw_pkg::PI_Q28) begin
			e_wrap = e_raw + ttdw_pkg::TWO_PI_Q28;
		end else begin
			e_wrap = e_raw;
		end
		err_new = 19'((e_wrap + 36'sd32768) >>> 16);
	end

	// commands and progress
	always_comb begin
		merr = err_q[18] ? 19'(-err_q) : 19'(err_q);
		hdiff = 16'(wh_q) - 16'(hd_q);
		mhdiff = hdiff[15] ? 16'(-hdiff) : 16'(hdiff);
		if (arrived_q) begin
			a_sel = (mhdiff <= 16'(head_tol_q)) ? 19'sd0 : 19'(hdiff);
		end else begin
			a_sel = (merr <= 19'(head_tol_q)) ? 19'sd0 : err_q;
		end
		ma = a_sel[18] ? 19'(-a_sel) : 19'(a_sel);
		if (ma > 19'(turn_lim_q)) begin
			ang = a_sel[18] ? -16'(turn_lim_q) : 16'(turn_lim_q);
		end else begin
			ang = 16'(a_sel);
		end
		near = dist_q <= 33'(pos_tol_q);
		dist0 = near ? 33'd0 : dist_q;
		if (merr < 19'(head_tol_q)) begin
			lin = (dist0 > 33'(lin_lim_q)) ? lin_lim_q : dist0[30:0];
		end else begin
			lin = '0;
		end
		arr_next = arrived_q | near;
		adv = (ang == 16'sd0) && (lin == 31'd0) && arr_next;
		if (!active_q) begin
			ang = '0;
			lin = '0;
			adv = 1'b0;
			arr_next = arrived_q;
		end
		pi_next = adv ? pi_q + CW'(1) : pi_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lin_lim_q <= ttdw_pkg::LIN_LIMIT_RST;
			turn_lim_q <= ttdw_pkg::TURN_LIMIT_RST;
			pos_tol_q <= ttdw_pkg::POS_TOL_RST;
			head_tol_q <= ttdw_pkg::HEAD_TOL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				ttdw_pkg::REG_LIN_LIMIT: lin_lim_q <= cfg_data;
				ttdw_pkg::REG_TURN_LIMIT: turn_lim_q <= cfg_data[14:0];
				ttdw_pkg::REG_POS_TOL: pos_tol_q <= cfg_data;
				ttdw_pkg::REG_HEAD_TOL: head_tol_q <= cfg_data[14:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			pi_q <= '0;
			arrived_q <= 1'b0;
			active_q <= 1'b0;
			start_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			start_q <= (state_q == S_RD);
			case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						case (in_ch.op)
							ttdw_pkg::OP_COMMIT: begin
								count_q <= (13'(in_ch.waypoint_total) > 13'(WAYPOINT_DEPTH))
									? CW'(WAYPOINT_DEPTH) : CW'(in_ch.waypoint_total);
								pi_q <= '0;
								arrived_q <= 1'b0;
							end
							ttdw_pkg::OP_POSE: begin
								active_q <= pi_q < count_q;
								state_q <= (pi_q < count_q) ? S_RD : S_FIN;
							end
							default: begin
							end
						endcase
					end
				end
				S_RD: begin
					state_q <= S_CALC;
				end
				S_CALC: begin
					if (c_done && d_done && !start_q) begin
						state_q <= S_ERR;
					end
				end
				S_ERR: state_q <= S_FIN;
				S_FIN: begin
					if (out_free) begin
						pi_q <= pi_next;
						arrived_q <= arr_next && !adv;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_ch.valid) begin
			px_q <= in_ch.pos_x;
			py_q <= in_ch.pos_y;
			hd_q <= in_ch.heading;
		end
		if (state_q == S_RD) begin
			dx_q <= 33'(signed'(rdata[78:47])) - 33'(px_q);
			dy_q <= 33'(signed'(rdata[46:15])) - 33'(py_q);
			wh_q <= rdata[14:0];
		end
		if (state_q == S_ERR) begin
			err_q <= err_new;
			dist_q <= dist_len;
		end
		if (state_q == S_FIN && out_free) begin
			out_ch.linear_velocity <= lin;
			out_ch.angular_velocity <= ang;
			out_ch.finished <= (pi_next == count_q);
			out_ch.target_index <= 7'(pi_next);
		end
	end

	`TTDW_ASSERT_NOW(a_pi_le_count, clk, arst_n, 1'b1, pi_q <= count_q, "progress beyond count")
	`TTDW_ASSERT_NOW(a_arrived_active, clk, arst_n, arrived_q, pi_q < count_q,
		"arrived with no waypoint")
	`TTDW_ASSERT_NEXT(a_fin_load, clk, arst_n, state_q == S_FIN && out_free,
		out_valid_q && state_q == S_IDLE, "result not loaded")
endmodule
